@@ hw/rtl/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the string escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_OCTAL  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;

  localparam logic [7:0] CC_BS = 8'd8;
  localparam logic [7:0] CC_FF = 8'd12;
  localparam logic [7:0] CC_LF = 8'd10;
  localparam logic [7:0] CC_CR = 8'd13;
  localparam logic [7:0] CC_HT = 8'd9;
  localparam logic [7:0] CC_VT = 8'd11;

  localparam int unsigned OctalDigitsMax = 3;
  localparam int unsigned ShownBits      = 16;

  typedef struct packed {
    logic [1:0] phase;
    logic [8:0] oct_val;
    logic [1:0] oct_dig;
  } esc_state_t;

  typedef struct packed {
    logic [7:0]  data;
    kind_e       kind;
    logic [15:0] length;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/sed_if.sv @@
// ----------------------------------------------------------------------------
// sed_in_if / sed_out_if
// Valid/ready channels for string body bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sed_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] length;

  modport source (output valid, output out_byte, output kind, output length, input ready);
  modport sink   (input valid, input out_byte, input kind, input length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/string_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes a string literal body one byte per request, escapes or raw copy.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_i      in   valid/ready     in_byte[7:0], in_last
//  out_o     out  valid/ready     out_byte[7:0], kind[1:0], length[15:0]
//  cfg       in   cfg_we_i        cfg_wdata_i (decode_escapes)
//
//  A byte request is decoded in the cycle it is accepted; its 0..2 results
//  land in a four-entry queue and leave one per cycle while out_o is ready.
//  Input accepts whenever the queue holds at most two results: one byte per
//  cycle sustained while out_o is ready and no byte yields two results.
//  Reset: escape mode on, string state and count cleared, queue empty.
//  A config write also clears string state and count.
// ----------------------------------------------------------------------------
`default_nettype none

module string_escape_decoder #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sed_in_if.sink     in_i,
  sed_out_if.source  out_o,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i
);

  logic                   mode_q;
  sed_pkg::esc_state_t    st_q, st_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  sed_pkg::push_t         dec_push, push;
  sed_pkg::res_t          res;
  logic                   space, accept;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  sed_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .mode_i (mode_q),
    .st_i   (st_q),
    .count_i(count_q),
    .byte_i (in_i.in_byte),
    .last_i (in_i.in_last),
    .st_o   (st_d),
    .count_o(count_d),
    .push_o (dec_push)
  );

  always_comb begin
    push = dec_push;
    if (!accept) begin
      push.n = 2'd0;
    end
  end

  sed_rq u_rq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .space_o(space),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .res_o  (res)
  );

  assign out_o.out_byte = res.data;
  assign out_o.kind     = res.kind;
  assign out_o.length   = res.length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      st_q    <= '{phase: sed_pkg::PH_NORMAL, oct_val: 9'd0, oct_dig: 2'd0};
      count_q <= '0;
    end else if (cfg_we_i) begin
      mode_q  <= cfg_wdata_i;
      st_q    <= '{phase: sed_pkg::PH_NORMAL, oct_val: 9'd0, oct_dig: 2'd0};
      count_q <= '0;
    end else if (accept) begin
      st_q    <= st_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sed_decode.sv @@
// ----------------------------------------------------------------------------
// sed_decode
// Per-byte decode: next escape state, next length count and up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_decode #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                   mode_i,
  input  wire sed_pkg::esc_state_t    st_i,
  input  wire logic [LENGTH_BITS-1:0] count_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   last_i,
  output sed_pkg::esc_state_t         st_o,
  output logic [LENGTH_BITS-1:0]      count_o,
  output sed_pkg::push_t              push_o
);

  localparam int unsigned WideBits =
    (LENGTH_BITS > sed_pkg::ShownBits) ? LENGTH_BITS : sed_pkg::ShownBits;
  localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};
  localparam logic [WideBits-1:0] ShownMax = WideBits'({sed_pkg::ShownBits{1'b1}});

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  function automatic logic [15:0] shown(input logic [LENGTH_BITS-1:0] c);
    logic [WideBits-1:0] w;
    w = WideBits'(c);
    if (w > ShownMax) begin
      w = ShownMax;
    end
    return w[15:0];
  endfunction

  function automatic sed_pkg::res_t mk(input logic [7:0] d, input sed_pkg::kind_e k,
                                       input logic [LENGTH_BITS-1:0] c);
    sed_pkg::res_t r;
    r.data   = d;
    r.kind   = k;
    r.length = shown(c);
    return r;
  endfunction

  localparam sed_pkg::esc_state_t StClear = '{phase: sed_pkg::PH_NORMAL,
                                              oct_val: 9'd0, oct_dig: 2'd0};

  logic [LENGTH_BITS-1:0] c1, c2;
  logic                   is_oct;
  logic [8:0]             oct_nv;
  logic [7:0]             esc_map;
  logic                   esc_simple;

  assign c1     = sat_inc(count_i);
  assign c2     = sat_inc(c1);
  assign is_oct = (byte_i >= sed_pkg::CH_ZERO) && (byte_i <= sed_pkg::CH_SEVEN);
  assign oct_nv = {st_i.oct_val[5:0], byte_i[2:0]};

  always_comb begin
    esc_simple = 1'b1;
    esc_map    = byte_i;
    case (byte_i)
      sed_pkg::CH_BSLASH, sed_pkg::CH_APOS, sed_pkg::CH_QUOTE: esc_map = byte_i;
      sed_pkg::CH_B: esc_map = sed_pkg::CC_BS;
      sed_pkg::CH_F: esc_map = sed_pkg::CC_FF;
      sed_pkg::CH_N: esc_map = sed_pkg::CC_LF;
      sed_pkg::CH_R: esc_map = sed_pkg::CC_CR;
      sed_pkg::CH_T: esc_map = sed_pkg::CC_HT;
      sed_pkg::CH_V: esc_map = sed_pkg::CC_VT;
      default:       esc_simple = 1'b0;
    endcase
  end

  always_comb begin
    st_o      = st_i;
    count_o   = count_i;
    push_o.n  = 2'd0;
    push_o.r0 = mk(8'd0, sed_pkg::KIND_DATA, c1);
    push_o.r1 = mk(8'd0, sed_pkg::KIND_DATA, c2);

    if (!mode_i) begin
      push_o.n  = 2'd1;
      push_o.r0 = mk(byte_i, sed_pkg::KIND_DATA, c1);
      count_o   = c1;
      if (last_i) begin
        push_o.n  = 2'd2;
        push_o.r1 = mk(8'd0, sed_pkg::KIND_END, c1);
        st_o      = StClear;
        count_o   = '0;
      end
    end else begin
      case (st_i.phase)
        sed_pkg::PH_ESC: begin
          st_o.phase = sed_pkg::PH_NORMAL;
          if (byte_i == sed_pkg::CH_NUL) begin
            push_o.n  = 2'd1;
            push_o.r0 = mk(8'd0, sed_pkg::KIND_ERR, count_i);
            st_o      = StClear;
            count_o   = '0;
          end else if (is_oct) begin
            st_o.phase   = sed_pkg::PH_OCTAL;
            st_o.oct_val = {6'd0, byte_i[2:0]};
            st_o.oct_dig = 2'd1;
          end else if (esc_simple) begin
            push_o.n  = 2'd1;
            push_o.r0 = mk(esc_map, sed_pkg::KIND_DATA, c1);
            count_o   = c1;
          end else begin
            push_o.n  = 2'd2;
            push_o.r0 = mk(sed_pkg::CH_BSLASH, sed_pkg::KIND_DATA, c1);
            push_o.r1 = mk(byte_i, sed_pkg::KIND_DATA, c2);
            count_o   = c2;
          end
        end
        sed_pkg::PH_OCTAL: begin
          if (is_oct) begin
            if (32'(st_i.oct_dig) + 32'd1 >= sed_pkg::OctalDigitsMax) begin
              push_o.n  = 2'd1;
              push_o.r0 = mk(oct_nv[7:0], sed_pkg::KIND_DATA, c1);
              count_o   = c1;
              st_o      = StClear;
            end else begin
              st_o.oct_val = oct_nv;
              st_o.oct_dig = st_i.oct_dig + 2'd1;
            end
          end else begin
            push_o.r0 = mk(st_i.oct_val[7:0], sed_pkg::KIND_DATA, c1);
            st_o      = StClear;
            push_o.n  = 2'd2;
            if (byte_i == sed_pkg::CH_QUOTE) begin
              push_o.r1 = mk(8'd0, sed_pkg::KIND_END, c1);
              count_o   = '0;
            end else if (byte_i == sed_pkg::CH_NUL) begin
              push_o.r1 = mk(8'd0, sed_pkg::KIND_ERR, c1);
              count_o   = '0;
            end else if (byte_i == sed_pkg::CH_BSLASH) begin
              push_o.n   = 2'd1;
              st_o.phase = sed_pkg::PH_ESC;
              count_o    = c1;
            end else begin
              push_o.r1 = mk(byte_i, sed_pkg::KIND_DATA, c2);
              count_o   = c2;
            end
          end
        end
        default: begin
          if (byte_i == sed_pkg::CH_QUOTE) begin
            push_o.n  = 2'd1;
            push_o.r0 = mk(8'd0, sed_pkg::KIND_END, count_i);
            st_o      = StClear;
            count_o   = '0;
          end else if (byte_i == sed_pkg::CH_NUL) begin
            push_o.n  = 2'd1;
            push_o.r0 = mk(8'd0, sed_pkg::KIND_ERR, count_i);
            st_o      = StClear;
            count_o   = '0;
          end else if (byte_i == sed_pkg::CH_BSLASH) begin
            st_o.phase = sed_pkg::PH_ESC;
          end else begin
            push_o.n  = 2'd1;
            push_o.r0 = mk(byte_i, sed_pkg::KIND_DATA, c1);
            count_o   = c1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sed_rq.sv @@
// ----------------------------------------------------------------------------
// sed_rq
// Four-entry result queue: up to two pushes a cycle, one pop while ready_i.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_rq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sed_pkg::push_t push_i,
  output logic                space_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output sed_pkg::res_t       res_o
);

  sed_pkg::res_t mem_q [4];
  logic [1:0]    wp_q, rp_q;
  logic [2:0]    cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != 3'd0);
  assign space_o = (cnt_q < 3'd3);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rp_q];
  assign cnt_d   = cnt_q + {1'b0, push_i.n} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wp_q + 2'd1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_q + push_i.n;
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sed_checker.sv @@
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks on the result channel of the string escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_byte_i,
  input wire logic [1:0]  kind_i,
  input wire logic [15:0] length_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(kind_i) && $stable(length_i))
    else $error("result changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == sed_pkg::KIND_DATA) || (kind_i == sed_pkg::KIND_END)
      || (kind_i == sed_pkg::KIND_ERR))
    else $error("bad result kind");

  a_final_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != sed_pkg::KIND_DATA) |-> out_byte_i == 8'd0)
    else $error("end or error carries a data byte");

  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == sed_pkg::KIND_DATA) |-> length_i != 16'd0)
    else $error("data result with zero length");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .kind_i     (out_o.kind),
  .length_i   (out_o.length)
);

`default_nettype wire
